// File: sv/ratu_pkg.sv
// ----------------------------------------------------------------------------
// ratu_pkg
// Shared types, constants and the character decode for the radix ASCII to
// unsigned 32-bit converter.
// ----------------------------------------------------------------------------
package ratu_pkg;

   // widths of the stream fields
   localparam int CharWidth   = 8;
   localparam int RadixWidth  = 6;
   localparam int ValueWidth  = 32;
   localparam int LenWidth    = 16;
   localparam int StatusWidth = 2;

   // register reset value and base limits
   localparam logic [RadixWidth-1:0] RadixReset   = 6'd10;
   localparam logic [RadixWidth-1:0] RadixMaxBase = 6'd62;
   localparam logic [RadixWidth-1:0] RadixAllOnes = 6'd63;

   // digit value that no base accepts
   localparam logic [RadixWidth-1:0] DigitNone = 6'd63;

   localparam logic [ValueWidth-1:0] ValueAllOnes = '1;
   localparam logic [LenWidth-1:0]   LenMax       = '1;

   localparam logic [CharWidth-1:0] CharPlus = 8'h2B;

   // result status codes
   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_NO_DIGITS = 2'd2
   } ratu_status_type;

   // map a character to its digit value, DigitNone for a non-digit
   function automatic logic [RadixWidth-1:0] digit_of(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] d;
      d = {2'b00, DigitNone};
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41 + 8'd10;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h61 + 8'd36;
      end
      return d[RadixWidth-1:0];
   endfunction

endpackage

// File: sv/radix_ascii_to_uint32_top.sv
// ----------------------------------------------------------------------------
// radix_ascii_to_uint32_top
// Streaming ASCII to unsigned 32-bit integer converter, bases 1 to 62.
// ----------------------------------------------------------------------------
//
//  channel  | group  | direction | contents
//  ---------+--------+-----------+------------------------------------------
//  request  | req_   | in        | tdata: ch[7:0]; tuser: first
//  response | rsp_   | out       | tdata: value[31:0], consumed_len[47:32];
//           |        |           | tuser: status[1:0]
//  control  | csr_   | in        | wr_en, wr_data: radix[5:0]
//
//  One character per cycle while the response slot is free. A character enters
//  the input register, then one stage of 32-by-6-bit multiply-add and saturation
//  updates the number state and loads the response register. Response valid rises
//  after the closing character has gone through the input and response registers.
//  Synchronous reset clears the number state, both valid flags and sets radix 10.
//  A stalled response holds the input register; the request side then stalls too.
//
module radix_ascii_to_uint32_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ratu_pkg::CharWidth-1:0] req_tdata,   // [7:0] ch
   input  logic                           req_tuser,   // [0] first
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,   // [31:0] value, [47:32] consumed_len
   output logic [ratu_pkg::StatusWidth-1:0] rsp_tuser, // [1:0] status
   // configuration
   input  logic                           csr_wr_en,
   input  logic [ratu_pkg::RadixWidth-1:0] csr_wr_data
);
   import ratu_pkg::*;

   // registers
   logic                   radix_ff;
   logic [RadixWidth-1:0]  radix_val_ff, radix_val_in;
   logic                   in_valid_ff, in_valid_in;
   logic [CharWidth-1:0]   in_ch_ff, in_ch_in;
   logic                   in_first_ff, in_first_in;
   logic [ValueWidth-1:0]  acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic [LenWidth-1:0]    cnt_ff, cnt_in;
   logic                   plus_ff, plus_in;
   logic                   active_ff, active_in;
   logic                   out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0]  out_value_ff, out_value_in;
   logic [LenWidth-1:0]    out_len_ff, out_len_in;
   ratu_status_type        out_status_ff, out_status_in;

   // datapath
   logic                   advance;
   logic [RadixWidth-1:0]  base;
   logic [RadixWidth-1:0]  digit;
   logic                   is_digit;
   logic                   cur_first_plus;
   logic                   consume;
   logic [ValueWidth-1:0]  cur_acc;
   logic                   cur_ovf;
   logic [LenWidth-1:0]    cur_cnt;
   logic                   cur_plus;
   logic [38:0]            prod_sum;
   logic [LenWidth:0]      len_sum;
   logic                   emit;

   // radix_ff is the registered copy of the register write strobe
   // effective base: zero means ten, sixty-three means sixty-two
   always_comb begin
      base = radix_val_ff;
      if (radix_val_ff == '0) begin
         base = RadixReset;
      end else if (radix_val_ff == RadixAllOnes) begin
         base = RadixMaxBase;
      end
   end

   // the input register moves on when the response slot is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // number state as seen by this character
   assign cur_first_plus = in_first_ff && (in_ch_ff == CharPlus);
   assign consume  = in_first_ff ? !cur_first_plus : active_ff;
   assign cur_acc  = in_first_ff ? '0 : acc_ff;
   assign cur_ovf  = in_first_ff ? 1'b0 : ovf_ff;
   assign cur_cnt  = in_first_ff ? '0 : cnt_ff;
   assign cur_plus = in_first_ff ? 1'b0 : plus_ff;

   assign digit    = digit_of(in_ch_ff);
   assign is_digit = digit < base;

   // multiply-add, overflow shows in the top bits
   assign prod_sum = {7'b0, cur_acc} * {33'b0, base} + {33'b0, digit};

   // length counts the plus sign, saturating
   assign len_sum = {1'b0, cur_cnt} + {{LenWidth{1'b0}}, cur_plus};

   assign emit = advance && consume && !is_digit;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      in_first_in = in_first_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_ch_in    = req_tdata;
         in_first_in = req_tuser;
      end
   end

   // number state update
   always_comb begin
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;
      plus_in   = plus_ff;
      active_in = active_ff;
      if (advance) begin
         if (cur_first_plus) begin
            acc_in    = '0;
            ovf_in    = 1'b0;
            cnt_in    = '0;
            plus_in   = 1'b1;
            active_in = 1'b1;
         end else if (consume && is_digit) begin
            acc_in    = cur_acc;
            ovf_in    = cur_ovf;
            if (!cur_ovf) begin
               if (prod_sum[38:32] != '0) begin
                  ovf_in = 1'b1;
                  acc_in = ValueAllOnes;
               end else begin
                  acc_in = prod_sum[31:0];
               end
            end
            cnt_in    = (cur_cnt == LenMax) ? LenMax : cur_cnt + 1'b1;
            plus_in   = cur_plus;
            active_in = 1'b1;
         end else if (consume) begin
            acc_in    = '0;
            ovf_in    = 1'b0;
            cnt_in    = '0;
            plus_in   = 1'b0;
            active_in = 1'b0;
         end
      end
   end

   // response register
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_value_in  = out_value_ff;
      out_len_in    = out_len_ff;
      out_status_in = out_status_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         if (cur_cnt == '0) begin
            out_value_in  = '0;
            out_len_in    = '0;
            out_status_in = STATUS_NO_DIGITS;
         end else begin
            out_value_in  = cur_ovf ? ValueAllOnes : cur_acc;
            out_len_in    = len_sum[LenWidth] ? LenMax : len_sum[LenWidth-1:0];
            out_status_in = cur_ovf ? STATUS_OVERFLOW : STATUS_OK;
         end
      end
   end

   // configuration register
   always_comb begin
      radix_val_in = radix_val_ff;
      if (csr_wr_en) begin
         radix_val_in = csr_wr_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_val_ff <= RadixReset;
         radix_ff     <= 1'b0;
         in_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         plus_ff      <= 1'b0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         radix_val_ff <= radix_val_in;
         radix_ff     <= csr_wr_en;
         in_valid_ff  <= in_valid_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         plus_ff      <= plus_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ch_ff      <= in_ch_in;
      in_first_ff   <= in_first_in;
      out_value_ff  <= out_value_in;
      out_len_ff    <= out_len_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_len_ff, out_value_ff};
   assign rsp_tuser  = out_status_ff;

   // checks

   // a number with no digits reports zero value and zero length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status_ff == STATUS_NO_DIGITS) |-> (out_value_ff == '0 && out_len_ff == '0))
      else $error("no-digit result carries a value or length");

   // an overflowed number reports all ones
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status_ff == STATUS_OVERFLOW) |-> (out_value_ff == ValueAllOnes && out_len_ff != '0))
      else $error("overflow result is not saturated");

   // a finished number with digits has a nonzero length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status_ff == STATUS_OK) |-> (out_len_ff != '0))
      else $error("ok result with zero length");

   // the number state returns to idle after a result is produced
   assert property (@(posedge clock) disable iff (reset)
      emit |=> (!active_ff && cnt_ff == '0 && !ovf_ff && !plus_ff))
      else $error("number state not cleared after result");

   // a configuration write shows in the radix register together with the registered strobe
   assert property (@(posedge clock) disable iff (reset)
      radix_ff |-> (radix_val_ff == $past(csr_wr_data)))
      else $error("radix register did not take the write");

endmodule

// File: tb/tb_radix_ascii_to_uint32_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_ascii_to_uint32_top
// Self-checking bench for the streaming ASCII to unsigned 32-bit converter.
// A queue of characters feeds a clocked stream driver with random gaps. A
// monitor converts every accepted character in its own copy of the number
// state and checks each response against the oldest pending number. The run
// covers several bases, malformed and noisy text, a run of zero digits after
// a plus sign and a long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_radix_ascii_to_uint32_top;
   import ratu_pkg::*;

   localparam int unsigned CycleLimit  = 1000000;
   localparam int          DrainCycles = 6;
   localparam int          LongHold    = 300;
   localparam int          LongRun     = 20;
   localparam int          PhaseItems  = 70;

   typedef struct {
      logic [CharWidth-1:0] ch;
      logic                 first;
      int                   gap;
   } char_item_type;

   typedef struct {
      logic [ValueWidth-1:0] value;
      ratu_status_type       status;
      logic [LenWidth-1:0]   len;
   } number_result_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [CharWidth-1:0]   req_tdata   = '0;
   logic                   req_tuser   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [47:0]            rsp_tdata;
   logic [StatusWidth-1:0] rsp_tuser;
   logic                   csr_wr_en   = 1'b0;
   logic [RadixWidth-1:0]  csr_wr_data = '0;

   radix_ascii_to_uint32_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shared bench state
   char_item_type       char_queue[$];
   number_result_type   expected_numbers[$];
   logic [RadixWidth-1:0] radix_shadow = RadixReset;
   int                  tx_mode = 1;
   int                  rx_mode = 1;
   int                  stall_orders = 0;
   int                  error_count = 0;
   int unsigned         cycle_count = 0;
   bit                  req_fire = 1'b0;
   bit                  rsp_fire = 1'b0;

   // shadow number state
   logic [ValueWidth-1:0] num_acc    = '0;
   bit                    num_ovf    = 1'b0;
   logic [LenWidth-1:0]   num_digits = '0;
   bit                    num_plus   = 1'b0;
   bit                    num_active = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int effective_base(input logic [RadixWidth-1:0] r);
      if (r == 6'd0) return 10;
      if (r == RadixAllOnes) return int'(RadixMaxBase);
      return int'(r);
   endfunction

   function automatic int char_digit(input logic [CharWidth-1:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 36;
      return int'(DigitNone);
   endfunction

   function automatic logic [CharWidth-1:0] digit_char(input int v);
      if (v < 10) return 8'(int'("0") + v);
      if (v < 36) return 8'(int'("A") + v - 10);
      return 8'(int'("a") + v - 36);
   endfunction

   function automatic void clear_number();
      num_acc    = '0;
      num_ovf    = 1'b0;
      num_digits = '0;
      num_plus   = 1'b0;
      num_active = 1'b0;
   endfunction

   // advance the shadow number by one character, returns 1 when a number ends
   function automatic bit convert_char(input logic [CharWidth-1:0] ch, input logic first,
                                       output number_result_type res);
      int          base;
      int          dval;
      logic [63:0] prod;
      int          len;
      base = effective_base(radix_shadow);
      res.value  = '0;
      res.status = STATUS_OK;
      res.len    = '0;
      if (first) begin
         clear_number();
         num_active = 1'b1;
         if (ch == CharPlus) begin
            num_plus = 1'b1;
            return 1'b0;
         end
      end else if (!num_active) begin
         return 1'b0;
      end
      dval = char_digit(ch);
      if (dval < base) begin
         if (!num_ovf) begin
            prod = 64'(num_acc) * 64'(base) + 64'(dval);
            if (prod > 64'hFFFF_FFFF) begin
               num_ovf = 1'b1;
               num_acc = ValueAllOnes;
            end else begin
               num_acc = prod[31:0];
            end
         end
         if (num_digits != LenMax) num_digits++;
         return 1'b0;
      end
      // non-digit closes the number
      if (num_digits == 0) begin
         res.status = STATUS_NO_DIGITS;
      end else begin
         len = int'(num_digits) + (num_plus ? 1 : 0);
         if (len > int'(LenMax)) len = int'(LenMax);
         res.value  = num_ovf ? ValueAllOnes : num_acc;
         res.status = num_ovf ? STATUS_OVERFLOW : STATUS_OK;
         res.len    = 16'(len);
      end
      clear_number();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // monitor: predict on request transfers, check on response transfers
   always @(posedge clock) begin
      number_result_type res;
      number_result_type want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         req_fire = req_tvalid && req_tready;
         rsp_fire = rsp_tvalid && rsp_tready;
         if (req_fire) begin
            if (convert_char(req_tdata, req_tuser, res)) expected_numbers.push_back(res);
         end
         if (rsp_fire) begin
            if (expected_numbers.size() == 0) begin
               report_mismatch("response with none pending", rsp_tdata, '0);
            end else begin
               want = expected_numbers.pop_front();
               if (rsp_tdata[31:0] !== want.value)
                  report_mismatch("value", 48'(rsp_tdata[31:0]), 48'(want.value));
               if (rsp_tdata[47:32] !== want.len)
                  report_mismatch("consumed_len", 48'(rsp_tdata[47:32]), 48'(want.len));
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 48'(rsp_tuser), 48'(want.status));
            end
         end
      end
   end

   // request driver
   int            tx_gap_left = 0;
   bit            tx_gap_loaded = 1'b0;
   char_item_type tx_item;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // hold the offered transfer
      end else if (char_queue.size() == 0) begin
         req_tvalid <= 1'b0;
      end else begin
         if (!tx_gap_loaded) begin
            tx_gap_left   = char_queue[0].gap;
            tx_gap_loaded = 1'b1;
         end
         if (tx_gap_left > 0) begin
            tx_gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            tx_item       = char_queue.pop_front();
            tx_gap_loaded = 1'b0;
            req_tdata    <= tx_item.ch;
            req_tuser    <= tx_item.first;
            req_tvalid   <= 1'b1;
         end
      end
   end

   function automatic int draw_gap(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 14);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      endcase
   endfunction

   // response ready, with a long hold-off on request
   int rx_wait_left = 0;
   int rx_hold_left = 0;
   int stall_served = 0;
   always @(negedge clock) begin
      if (rsp_fire) rx_wait_left = draw_gap(rx_mode);
      if (stall_orders != stall_served) begin
         stall_served++;
         rx_hold_left = LongHold;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_wait_left > 0) begin
         rx_wait_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // stimulus helpers
   task automatic push_char(input logic [CharWidth-1:0] ch, input logic first);
      char_item_type it;
      it.ch    = ch;
      it.first = first;
      it.gap   = draw_gap(tx_mode);
      char_queue.push_back(it);
   endtask

   task automatic push_text(input string s, input bit mark_first);
      for (int i = 0; i < s.len(); i++) push_char(s[i], mark_first && i == 0);
   endtask

   task automatic wait_idle();
      while (char_queue.size() != 0 || req_tvalid || expected_numbers.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic program_radix(input logic [RadixWidth-1:0] r);
      @(negedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= r;
      radix_shadow  = r;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   function automatic logic [CharWidth-1:0] pick_nondigit(input int base);
      logic [CharWidth-1:0] c;
      do c = 8'($urandom_range(0, 255)); while (char_digit(c) < base);
      return c;
   endfunction

   // random text: mostly well-formed numbers, some noise and broken runs
   task automatic gen_random_items(input int n);
      int count;
      int base;
      int ndig;
      int pick;
      bit noise_first;
      count = 0;
      base  = effective_base(radix_shadow);
      while (count < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 3) == 0) push_char(CharPlus, 1'b1);
            else push_char(digit_char($urandom_range(0, base - 1)), 1'b1);
            ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
            repeat (ndig) push_char(digit_char($urandom_range(0, base - 1)), 1'b0);
            push_char(pick_nondigit(base), $urandom_range(0, 9) == 0);
            count += ndig + 2;
         end else if (pick < 85) begin
            noise_first = $urandom_range(0, 1);
            push_char(8'($urandom_range(0, 255)), noise_first);
            if (noise_first) count++;
         end else if (pick < 92) begin
            // plus sign followed by another plus
            push_char(CharPlus, 1'b1);
            push_char(CharPlus, 1'b0);
            count += 2;
         end else begin
            // number dropped by a fresh first
            ndig = $urandom_range(1, 5);
            push_char(digit_char($urandom_range(0, base - 1)), 1'b1);
            repeat (ndig) push_char(digit_char($urandom_range(0, base - 1)), 1'b0);
            count += ndig + 1;
         end
      end
   endtask

   // main sequence
   logic [RadixWidth-1:0] phase_radix[$] = '{6'd10, 6'd2, 6'd62, 6'd16, 6'd36,
                                             6'd0, 6'd1, 6'd63};
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed text at the reset base
      tx_mode = 1;
      rx_mode = 1;
      push_text("+12 ", 1'b1);
      push_text("4294967295;", 1'b1);
      push_text("4294967296x", 1'b1);
      push_text("+-", 1'b1);
      push_text("z", 1'b1);
      push_char("7", 1'b0);
      push_text("5", 1'b1);
      push_text("78+", 1'b1);
      push_char(8'hFF, 1'b1);
      push_char("9", 1'b1);
      push_char(8'h00, 1'b0);
      wait_idle();

      // base extremes and the out-of-range settings
      program_radix(RadixMaxBase);
      push_text("zZ9.", 1'b1);
      push_text("zzzzzzzz/", 1'b1);
      wait_idle();
      program_radix(6'd2);
      push_text("1012", 1'b1);
      wait_idle();
      program_radix(6'd1);
      push_text("01 ", 1'b1);
      wait_idle();
      program_radix(6'd0);
      push_text("99a", 1'b1);
      wait_idle();
      program_radix(RadixAllOnes);
      push_text("+zy{", 1'b1);
      wait_idle();

      // back-to-back run of zeros after a plus sign
      program_radix(6'd10);
      tx_mode = 0;
      push_char(CharPlus, 1'b1);
      repeat (LongRun) push_char("0", 1'b0);
      push_char(" ", 1'b0);
      wait_idle();

      // random phases
      for (int p = 0; p < 12; p++) begin
         if (p < phase_radix.size()) program_radix(phase_radix[p]);
         else program_radix(6'($urandom_range(0, 63)));
         tx_mode = p % 3;
         rx_mode = (p / 3) % 3;
         if (p == 3) begin
            // receiver stalls long while characters keep coming
            tx_mode = 0;
            stall_orders++;
         end
         gen_random_items(PhaseItems);
         wait_idle();
      end

      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
sv/ratu_pkg.sv
sv/radix_ascii_to_uint32_top.sv
tb/tb_radix_ascii_to_uint32_top.sv
